/* src/interpolating_pcm_window_store_macros.svh */
// Assertion macros for the interpolating PCM window store checker.
// Depends on a clk and an active-low arst_n in the scope of each use.
`ifndef INTERPOLATING_PCM_WINDOW_STORE_MACROS_SVH
`define INTERPOLATING_PCM_WINDOW_STORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define IPWS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define IPWS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/ipws_pkg.sv */
// Shared types and constants of the interpolating PCM window store.
// No dependencies; imported by every module of the block but ipws_store.
package ipws_pkg;

	// request kinds
	typedef enum logic [1:0] {
		REQ_WRITE   = 2'd0,
		REQ_PUBLISH = 2'd1,
		REQ_READ    = 2'd2,
		REQ_PLAN    = 2'd3
	} req_kind_t;

	// configuration port
	localparam int CFG_IW = 1;
	localparam int CFG_DW = 13;
	localparam logic [CFG_IW-1:0] CFG_CHANNELS = 1'b0;
	localparam logic [CFG_IW-1:0] CFG_CAPACITY = 1'b1;
	localparam logic [3:0]  CHANNELS_RESET = 4'd1;
	localparam logic [12:0] CAPACITY_RESET = 13'd4096;

	// width of frame*channels+channel before it is cut to the store address
	localparam int ADDR_CALC_W = 18;

	// request word
	typedef struct packed {
		req_kind_t           req_type;
		logic [11:0]         frame_index;
		logic [2:0]          channel;
		logic signed [23:0]  sample_value;
		logic signed [63:0]  frame_number;
		logic [12:0]         frame_span;
		logic signed [63:0]  source_total;
		logic [62:0]         position;
		logic [63:0]         generation;
		logic [63:0]         epoch;
	} req_t;

	// result word
	typedef struct packed {
		logic                accepted;
		logic signed [23:0]  sample_out;
		logic [62:0]         range_first;
		logic [12:0]         range_count;
		logic [63:0]         window_generation;
		logic [63:0]         window_epoch;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic eval;
		logic rd_a;
		logic rd_b;
		logic mix;
		logic plan;
		logic fin;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		req_kind_t kind;
		logic      rd_ok;
	} dp_status_t;

endpackage

/* src/interpolating_pcm_window_store.sv */
// Steps from accept to the done strobe: evaluate, then finish; a plan adds a plan step,
// a read two reads of the single-port sample store, then a multiply (a rejected read stops after the first).
// A new word is taken in the cycle that done shows.
// Reset sets one channel, capacity 4096 and an empty window with zero tags;
// the sample store is not cleared and has no reset sequence. done cannot be held off.
module interpolating_pcm_window_store import ipws_pkg::*; #(
	parameter int MAX_FRAMES   = 4096,
	parameter int MAX_CHANNELS = 8,
	parameter int FRAC_BITS    = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [CFG_DW-1:0] cfg_data,
	input  logic              start,
	input  req_t              req,
	output logic              busy,
	output logic              done,
	output rsp_t              rsp
);

	ctrl_cmd_t  cmd;
	dp_status_t st;

	ipws_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.st     (st),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	ipws_dp #(
		.MAX_FRAMES   (MAX_FRAMES),
		.MAX_CHANNELS (MAX_CHANNELS),
		.FRAC_BITS    (FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req),
		.cmd       (cmd),
		.st        (st),
		.rsp       (rsp)
	);

endmodule

/* src/ipws_store.sv */
// Single-port sample store with registered read data.
// Depends on nothing; used by ipws_dp.
module ipws_store #(
	parameter int DEPTH = 32768,
	parameter int AW    = 15
) (
	input  logic                clk,
	input  logic                we,
	input  logic                re,
	input  logic [AW-1:0]       addr,
	input  logic signed [23:0]  wdata,
	output logic signed [23:0]  rdata
);

	logic signed [23:0] mem [DEPTH];

	// one access per cycle: write or read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

/* src/ipws_dp.sv */
// Datapath: configuration, window registers, request checks, interpolation, plan.
// Depends on ipws_pkg and ipws_store.
module ipws_dp import ipws_pkg::*; #(
	parameter int MAX_FRAMES   = 4096,
	parameter int MAX_CHANNELS = 8,
	parameter int FRAC_BITS    = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [CFG_DW-1:0] cfg_data,
	input  req_t              req,
	input  ctrl_cmd_t         cmd,
	output dp_status_t        st,
	output rsp_t              rsp
);

	localparam int DEPTH   = MAX_FRAMES * MAX_CHANNELS;
	localparam int AW      = $clog2(DEPTH);
	localparam int WHOLE_W = 63 - FRAC_BITS;
	localparam int PRW     = 26 + FRAC_BITS;

	req_t req_q;
	rsp_t rsp_q;
	logic [3:0]  cfg_ch_q;
	logic [12:0] cfg_cap_q;
	logic [3:0]  chs;
	logic [12:0] cap;

	logic [62:0] ws_q;
	logic [12:0] wf_q;
	logic [63:0] gen_q;
	logic [63:0] epoch_q;

	logic                  acc_q;
	logic                  in_win_q;
	logic [12:0]           rel_q;
	logic [FRAC_BITS-1:0]  frac_q;
	logic [AW-1:0]         addr_a_q;
	logic signed [23:0]    a_q;
	logic signed [PRW-1:0] prod_q;
	logic                  pos_tot_q;
	logic [12:0]           count_q;
	logic signed [63:0]    anchor_q;
	logic signed [63:0]    first_q;
	logic signed [63:0]    maxf_q;

	logic                   wr_ok;
	logic                   pub_ok;
	logic                   in_win;
	logic                   rd_ok;
	logic [ADDR_CALC_W-1:0] wr_addr_full;
	logic [ADDR_CALC_W-1:0] rd_addr_full;
	logic [AW-1:0]          rd_addr;
	logic [AW-1:0]          mem_addr;
	logic                   mem_we;
	logic                   mem_re;
	logic signed [23:0]     rd_data;
	logic [63:0]            pub_sum;
	logic [WHOLE_W-1:0]     whole;
	logic [63:0]            win_diff;
	logic signed [24:0]     diff_ab;
	logic signed [PRW-1:0]  step;
	logic signed [PRW-1:0]  mixed_sum;
	logic signed [63:0]     total;
	logic signed [63:0]     fnum;
	logic signed [63:0]     cap64;
	logic [12:0]            count_n;
	logic signed [63:0]     anchor_n;
	logic signed [63:0]     first_c;
	logic signed [63:0]     first_f;

	// effective channel count and capacity
	always_comb begin
		if (cfg_ch_q == '0) begin
			chs = 4'd1;
		end else if (32'(cfg_ch_q) > MAX_CHANNELS) begin
			chs = 4'(MAX_CHANNELS);
		end else begin
			chs = cfg_ch_q;
		end
		if (cfg_cap_q == '0) begin
			cap = 13'd1;
		end else if (32'(cfg_cap_q) > MAX_FRAMES) begin
			cap = 13'(MAX_FRAMES);
		end else begin
			cap = cfg_cap_q;
		end
	end

	// sample write check and address
	assign wr_ok = ({1'b0, req_q.channel} < chs) && ({1'b0, req_q.frame_index} < cap);
	assign wr_addr_full = ADDR_CALC_W'(req_q.frame_index) * ADDR_CALC_W'(chs)
		+ ADDR_CALC_W'(req_q.channel);

	// publish check: start >= 0, count within capacity, last frame fits 63 bits
	assign pub_sum = 64'(req_q.frame_number[62:0]) + 64'(req_q.frame_span);
	assign pub_ok  = !req_q.frame_number[63] && (req_q.frame_span <= cap)
		&& (pub_sum <= 64'h8000_0000_0000_0000);

	// read window check
	assign whole    = req_q.position[62:FRAC_BITS];
	assign win_diff = 64'(whole) - 64'(ws_q);
	assign in_win   = ({1'b0, req_q.channel} < chs) && (wf_q != '0) && !win_diff[63]
		&& (win_diff[62:0] < 63'(wf_q));
	assign rd_ok = in_win_q && ((frac_q == '0) || ((14'(rel_q) + 14'd1) < 14'(wf_q)));
	assign rd_addr_full = ADDR_CALC_W'(rel_q) * ADDR_CALC_W'(chs)
		+ ADDR_CALC_W'(req_q.channel);
	assign rd_addr = AW'(rd_addr_full);

	// store port steering
	always_comb begin
		mem_we   = cmd.eval && (req_q.req_type == REQ_WRITE) && wr_ok;
		mem_re   = (cmd.rd_a && rd_ok) || (cmd.rd_b && (frac_q != '0));
		mem_addr = addr_a_q + AW'(chs);
		if (cmd.eval) begin
			mem_addr = AW'(wr_addr_full);
		end else if (cmd.rd_a) begin
			mem_addr = rd_addr;
		end
	end

	ipws_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.re    (mem_re),
		.addr  (mem_addr),
		.wdata (req_q.sample_value),
		.rdata (rd_data)
	);

	// interpolation arithmetic: floor of the product shifted down
	assign diff_ab   = 25'(rd_data) - 25'(a_q);
	assign step      = prod_q >>> FRAC_BITS;
	assign mixed_sum = PRW'(a_q) + step;

	// plan arithmetic
	assign total = req_q.source_total;
	assign fnum  = req_q.frame_number;
	assign cap64 = signed'(64'(cap));
	always_comb begin
		count_n = (total < cap64) ? total[12:0] : cap;
		if (fnum < 64'sd0) begin
			anchor_n = '0;
		end else if (fnum >= total) begin
			anchor_n = total - 64'sd1;
		end else begin
			anchor_n = fnum;
		end
		first_c = (first_q > maxf_q) ? maxf_q : first_q;
		first_f = (first_c < 64'sd0) ? 64'sd0 : first_c;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_ch_q  <= CHANNELS_RESET;
			cfg_cap_q <= CAPACITY_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CHANNELS: cfg_ch_q  <= cfg_data[3:0];
				CFG_CAPACITY: cfg_cap_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// published window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q    <= '0;
			wf_q    <= '0;
			gen_q   <= '0;
			epoch_q <= '0;
		end else if (cmd.eval && (req_q.req_type == REQ_PUBLISH) && pub_ok) begin
			ws_q    <= req_q.frame_number[62:0];
			wf_q    <= req_q.frame_span;
			gen_q   <= req_q.generation;
			epoch_q <= req_q.epoch;
		end
	end

	// request word and working registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req;
		end
		if (cmd.eval) begin
			in_win_q  <= in_win;
			rel_q     <= win_diff[12:0];
			frac_q    <= req_q.position[FRAC_BITS-1:0];
			pos_tot_q <= (total > 64'sd0);
			count_q   <= count_n;
			anchor_q  <= anchor_n;
			unique case (req_q.req_type)
				REQ_WRITE:   acc_q <= wr_ok;
				REQ_PUBLISH: acc_q <= pub_ok;
				REQ_READ:    acc_q <= 1'b0;
				REQ_PLAN:    acc_q <= 1'b1;
				default:     acc_q <= 1'b0;
			endcase
		end
		if (cmd.rd_a) begin
			acc_q    <= rd_ok;
			addr_a_q <= rd_addr;
		end
		if (cmd.rd_b) begin
			a_q <= rd_data;
		end
		if (cmd.mix) begin
			prod_q <= PRW'(diff_ab) * PRW'($signed({1'b0, frac_q}));
		end
		if (cmd.plan) begin
			first_q <= anchor_q - signed'(64'(count_q >> 1));
			maxf_q  <= total - signed'(64'(count_q));
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			rsp_q.accepted          <= acc_q;
			rsp_q.sample_out        <= '0;
			rsp_q.range_first       <= '0;
			rsp_q.range_count       <= '0;
			rsp_q.window_generation <= gen_q;
			rsp_q.window_epoch      <= epoch_q;
			if ((req_q.req_type == REQ_READ) && acc_q) begin
				rsp_q.sample_out <= (frac_q == '0) ? a_q : mixed_sum[23:0];
			end
			if ((req_q.req_type == REQ_PLAN) && pos_tot_q) begin
				rsp_q.range_first <= first_f[62:0];
				rsp_q.range_count <= count_q;
			end
		end
	end

	assign st.kind  = req_q.req_type;
	assign st.rd_ok = rd_ok;
	assign rsp      = rsp_q;

endmodule

/* src/ipws_ctrl.sv */
// Controller state machine: sequences each request through the datapath.
// Depends on ipws_pkg.
module ipws_ctrl import ipws_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  dp_status_t st,
	output logic       busy,
	output logic       done,
	output ctrl_cmd_t  cmd
);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_EVAL = 7'b0000010,
		S_RD_A = 7'b0000100,
		S_RD_B = 7'b0001000,
		S_MIX  = 7'b0010000,
		S_PLAN = 7'b0100000,
		S_FIN  = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_n;
	logic   done_q;

	// next state and commands
	always_comb begin
		state_n = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.capture = start;
				if (start) begin
					state_n = S_EVAL;
				end
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				unique case (st.kind)
					REQ_READ: state_n = S_RD_A;
					REQ_PLAN: state_n = S_PLAN;
					default:  state_n = S_FIN;
				endcase
			end
			S_RD_A: begin
				cmd.rd_a = 1'b1;
				state_n  = st.rd_ok ? S_RD_B : S_FIN;
			end
			S_RD_B: begin
				cmd.rd_b = 1'b1;
				state_n  = S_MIX;
			end
			S_MIX: begin
				cmd.mix = 1'b1;
				state_n = S_FIN;
			end
			S_PLAN: begin
				cmd.plan = 1'b1;
				state_n  = S_FIN;
			end
			S_FIN: begin
				cmd.fin = 1'b1;
				state_n = S_IDLE;
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			done_q  <= (state_q == S_FIN);
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule

/* src/ipws_checker.sv */
// Port-level checks of the interpolating PCM window store, bound to the top level.
// Depends on ipws_pkg and interpolating_pcm_window_store_macros.svh.
`include "interpolating_pcm_window_store_macros.svh"

module ipws_checker import ipws_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input rsp_t rsp
);

	// an accepted word keeps the block busy and gives no result yet
	`IPWS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accept did not raise busy")
	`IPWS_ASSERT_NEXT(a_accept_no_done, start && !busy, !done, "result too early")
	// a result ends the request
	`IPWS_ASSERT_NOW(a_done_idle, done, !busy, "done while busy")
	`IPWS_ASSERT_NEXT(a_done_single, done, !done, "result repeated")
	// rejected requests give a zero sample
	`IPWS_ASSERT_NOW(a_reject_zero, done && !rsp.accepted, rsp.sample_out == '0, "nonzero reject")

endmodule

bind interpolating_pcm_window_store ipws_checker u_ipws_checker (.*);

/* sim/tb_interpolating_pcm_window_store.sv */
// Testbench for the interpolating PCM window store: directed and random request words,
// checked field by field against a behavioral mirror of the store and window.
// Depends on ipws_pkg and interpolating_pcm_window_store.
`timescale 1ns / 1ps

module tb_interpolating_pcm_window_store;
	import ipws_pkg::*;

	localparam int FRAC = 16;
	localparam int STORE_WORDS = 4096 * 8;
	localparam int PHASE_WORDS = 440;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;

	// mirror of the store and published window; holds the results still due
	class pcm_window_mirror;
		logic signed [23:0] samples [STORE_WORDS];
		bit written [STORE_WORDS];
		logic [63:0] win_start;
		logic [12:0] win_frames;
		logic [63:0] cur_gen;
		logic [63:0] cur_epoch;
		logic [3:0] ch_reg;
		logic [12:0] cap_reg;
		bit blank_read;
		rsp_t due_results[$];
		int mismatches;
		int checked;

		function new();
			for (int i = 0; i < STORE_WORDS; i++) begin
				samples[i] = '0;
				written[i] = 1'b0;
			end
			win_start = '0;
			win_frames = '0;
			cur_gen = '0;
			cur_epoch = '0;
			ch_reg = CHANNELS_RESET;
			cap_reg = CAPACITY_RESET;
			mismatches = 0;
			checked = 0;
		endfunction

		function logic [63:0] channels();
			if (ch_reg == 0) return 64'd1;
			if (ch_reg > 8) return 64'd8;
			return 64'(ch_reg);
		endfunction

		function logic [63:0] capacity();
			if (cap_reg == 0) return 64'd1;
			if (cap_reg > 4096) return 64'd4096;
			return 64'(cap_reg);
		endfunction

		function void set_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
			if (idx == CFG_CHANNELS)
				ch_reg = val[3:0];
			else
				cap_reg = val;
		endfunction

		// expected result of one word; state changes only when commit is set
		function rsp_t resolve(req_t w, bit commit);
			rsp_t r;
			logic [63:0] chs, cap, whole, rel, fnum_u;
			logic [15:0] frac;
			longint a, b, prod, total, cnt, anchor, first, maxfirst;
			int unsigned addr;
			chs = channels();
			cap = capacity();
			r = '0;
			blank_read = 1'b0;
			case (w.req_type)
				REQ_WRITE: begin
					if (64'(w.channel) < chs && 64'(w.frame_index) < cap) begin
						addr = int'(64'(w.frame_index) * chs + 64'(w.channel));
						if (commit) begin
							samples[addr] = w.sample_value;
							written[addr] = 1'b1;
						end
						r.accepted = 1'b1;
					end
				end
				REQ_PUBLISH: begin
					fnum_u = w.frame_number;
					if (!fnum_u[63] && 64'(w.frame_span) <= cap &&
							(w.frame_span == 0 ||
							fnum_u <= S64_MAX - (64'(w.frame_span) - 64'd1))) begin
						if (commit) begin
							win_start = fnum_u;
							win_frames = w.frame_span;
							cur_gen = w.generation;
							cur_epoch = w.epoch;
						end
						r.accepted = 1'b1;
					end
				end
				REQ_READ: begin
					whole = 64'(w.position[62:FRAC]);
					frac = w.position[FRAC-1:0];
					if (64'(w.channel) < chs && win_frames != 0 && whole >= win_start &&
							whole - win_start < 64'(win_frames)) begin
						rel = whole - win_start;
						addr = int'(rel * chs + 64'(w.channel));
						if (frac == 0) begin
							r.sample_out = samples[addr];
							blank_read = !written[addr];
							r.accepted = 1'b1;
						end else if (rel + 64'd1 < 64'(win_frames)) begin
							a = samples[addr];
							b = samples[addr + int'(chs)];
							blank_read = !written[addr] || !written[addr + int'(chs)];
							// floor of the scaled difference: arithmetic shift of the product
							prod = (b - a) * longint'({48'b0, frac});
							r.sample_out = 24'(a + (prod >>> FRAC));
							r.accepted = 1'b1;
						end
					end
				end
				default: begin
					r.accepted = 1'b1;
					total = w.source_total;
					if (total > 0) begin
						cnt = (total < longint'(cap)) ? total : longint'(cap);
						anchor = w.frame_number;
						if (anchor < 0)
							anchor = 0;
						else if (anchor > total - 1)
							anchor = total - 1;
						first = anchor - cnt / 2;
						maxfirst = total - cnt;
						if (first > maxfirst) first = maxfirst;
						if (first < 0) first = 0;
						r.range_first = 63'(first);
						r.range_count = 13'(cnt);
					end
				end
			endcase
			r.window_generation = cur_gen;
			r.window_epoch = cur_epoch;
			return r;
		endfunction

		function void note_request(req_t w);
			due_results.push_back(resolve(w, 1'b1));
		endfunction

		function bit field_ok(string nm, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch, expected %h, actual %h", $time, nm, want, got);
				return 1'b0;
			end
			return 1'b1;
		endfunction

		function void check_result(rsp_t got);
			rsp_t want;
			bit ok;
			if (due_results.size() == 0) begin
				mismatches++;
				$display("%0t: result with nothing due, expected none, actual %h", $time, got);
				return;
			end
			want = due_results.pop_front();
			checked++;
			ok = 1'b1;
			ok &= field_ok("accepted", 64'(want.accepted), 64'(got.accepted));
			ok &= field_ok("sample_out", 64'(want.sample_out), 64'(got.sample_out));
			ok &= field_ok("range_first", 64'(want.range_first), 64'(got.range_first));
			ok &= field_ok("range_count", 64'(want.range_count), 64'(got.range_count));
			ok &= field_ok("window_generation", want.window_generation, got.window_generation);
			ok &= field_ok("window_epoch", want.window_epoch, got.window_epoch);
			if (!ok) mismatches++;
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IW-1:0] cfg_index;
	logic [CFG_DW-1:0] cfg_data;
	logic start;
	req_t req;
	logic busy;
	logic done;
	rsp_t rsp;

	pcm_window_mirror mirror;
	int idle_pct = 0;
	int words_sent = 0;
	int cfg_writes = 0;
	int idle_cycles = 0;

	interpolating_pcm_window_store u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.start     (start),
		.req       (req),
		.busy      (busy),
		.done      (done),
		.rsp       (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// results are sampled mid-cycle, away from the driving edge
	always @(negedge clk) begin
		if (arst_n === 1'b1 && done === 1'b1)
			mirror.check_result(rsp);
	end

	// watchdog: cycles with neither a word taken nor a result shown
	always @(negedge clk) begin
		if (arst_n !== 1'b1 || (start && !busy) || done === 1'b1) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, idle_cycles);
				$display("tb_interpolating_pcm_window_store: FAIL");
				$finish;
			end
		end
	end

	function automatic req_t rand_word();
		req_t w;
		w.req_type = req_kind_t'($urandom_range(3));
		w.frame_index = 12'($urandom);
		w.channel = 3'($urandom);
		w.sample_value = 24'($urandom);
		w.frame_number = {$urandom, $urandom};
		w.frame_span = 13'($urandom);
		w.source_total = {$urandom, $urandom};
		w.position = 63'({$urandom, $urandom});
		w.generation = {$urandom, $urandom};
		w.epoch = {$urandom, $urandom};
		return w;
	endfunction

	function automatic req_t mk_write(logic [11:0] f, logic [2:0] ch, logic [23:0] v);
		req_t w;
		w = rand_word();
		w.req_type = REQ_WRITE;
		w.frame_index = f;
		w.channel = ch;
		w.sample_value = v;
		return w;
	endfunction

	function automatic req_t mk_publish(logic [63:0] fnum, logic [12:0] cnt,
			logic [63:0] g, logic [63:0] e);
		req_t w;
		w = rand_word();
		w.req_type = REQ_PUBLISH;
		w.frame_number = fnum;
		w.frame_span = cnt;
		w.generation = g;
		w.epoch = e;
		return w;
	endfunction

	function automatic req_t mk_read(logic [62:0] pos, logic [2:0] ch);
		req_t w;
		w = rand_word();
		w.req_type = REQ_READ;
		w.position = pos;
		w.channel = ch;
		return w;
	endfunction

	function automatic req_t mk_plan(logic [63:0] anchor, logic [63:0] total);
		req_t w;
		w = rand_word();
		w.req_type = REQ_PLAN;
		w.frame_number = anchor;
		w.source_total = total;
		return w;
	endfunction

	function automatic logic [23:0] rand_sample();
		case ($urandom_range(7))
			0: return 24'h7FFFFF;
			1: return 24'h800000;
			2: return 24'h000000;
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic logic [CFG_DW-1:0] pick_channels();
		logic [CFG_DW-1:0] v;
		v = CFG_DW'($urandom);
		case ($urandom_range(6))
			0: v[3:0] = 4'd1;
			1: v[3:0] = 4'd8;
			2: v[3:0] = 4'd0;
			3: v[3:0] = 4'($urandom_range(9, 15));
			default: v[3:0] = 4'($urandom_range(1, 8));
		endcase
		return v;
	endfunction

	function automatic logic [CFG_DW-1:0] pick_capacity();
		case ($urandom_range(7))
			0: return 13'd1;
			1: return 13'd4096;
			2: return 13'd0;
			3: return 13'($urandom_range(4097, 8191));
			4: return 13'd2;
			default: return 13'($urandom_range(2, 64));
		endcase
	endfunction

	// drive one word and hold it until taken; reads of unwritten entries are dropped
	task automatic send_word(req_t w);
		bit taken;
		void'(mirror.resolve(w, 1'b0));
		if (!(w.req_type == REQ_READ && mirror.blank_read)) begin
			while ($urandom_range(99) < idle_pct) begin
				start <= 1'b0;
				@(posedge clk);
			end
			start <= 1'b1;
			req <= w;
			taken = 1'b0;
			while (!taken) begin
				@(negedge clk);
				taken = !busy;
				@(posedge clk);
			end
			mirror.note_request(w);
			words_sent++;
		end
	endtask

	// let every due result arrive, then wait with start low
	task automatic drain();
		start <= 1'b0;
		while (mirror.due_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_regs(logic [CFG_DW-1:0] ch_data, logic [CFG_DW-1:0] cap_data);
		cfg_we <= 1'b1;
		cfg_index <= CFG_CHANNELS;
		cfg_data <= ch_data;
		@(posedge clk);
		mirror.set_reg(CFG_CHANNELS, ch_data);
		cfg_index <= CFG_CAPACITY;
		cfg_data <= cap_data;
		@(posedge clk);
		mirror.set_reg(CFG_CAPACITY, cap_data);
		cfg_we <= 1'b0;
		cfg_writes += 2;
	endtask

	// one scene: usually publish a small window, fill it, then mostly reads with some noise
	task automatic run_scene();
		int n, span, chs, cap, steps, k, rel, f, c;
		int unsigned addr;
		logic [63:0] s, whole, total, anchor;
		logic [15:0] frac;
		logic [2:0] ch;
		chs = int'(mirror.channels());
		cap = int'(mirror.capacity());
		if ($urandom_range(4) != 0) begin
			n = $urandom_range(1, cap < 10 ? cap : 10);
			case ($urandom_range(5))
				0: s = 64'd0;
				1: s = (64'd1 << 47) - 64'(n);
				default: s = 64'($urandom_range(0, 1 << 20));
			endcase
			send_word(mk_publish(s, 13'(n), {$urandom, $urandom}, {$urandom, $urandom}));
		end
		span = mirror.win_frames < 12 ? int'(mirror.win_frames) : 12;
		for (f = 0; f < span; f++) begin
			for (c = 0; c < chs; c++) begin
				addr = f * chs + c;
				if (!mirror.written[addr] || $urandom_range(3) == 0)
					send_word(mk_write(12'(f), 3'(c), rand_sample()));
			end
		end
		steps = $urandom_range(10, 25);
		repeat (steps) begin
			k = $urandom_range(99);
			if (k < 50 && span > 0) begin
				// read inside the window
				rel = $urandom_range(0, span - 1);
				whole = mirror.win_start + 64'(rel);
				case ($urandom_range(7))
					0, 1: frac = 16'h0000;
					2: frac = 16'hFFFF;
					3: frac = 16'h0001;
					default: frac = 16'($urandom);
				endcase
				ch = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(0, chs - 1));
				if (whole[63:47] == 0)
					send_word(mk_read({whole[46:0], frac}, ch));
				else
					send_word(mk_read(63'({$urandom, $urandom}), ch));
			end else if (k < 60) begin
				// read just outside the window
				if ($urandom_range(1))
					whole = mirror.win_start + 64'(mirror.win_frames) + 64'($urandom_range(0, 2));
				else
					whole = mirror.win_start - 64'd1 - 64'($urandom_range(0, 2));
				send_word(mk_read({whole[46:0], 16'($urandom)}, 3'($urandom_range(0, chs - 1))));
			end else if (k < 75) begin
				case ($urandom_range(5))
					0: total = 64'd0;
					1: total = {1'b1, 31'($urandom), $urandom};
					2: total = 64'($urandom_range(1, 20));
					3: total = 64'(cap + $urandom_range(0, 3) - 1);
					4: total = {1'b0, 31'($urandom), $urandom};
					default: total = S64_MAX;
				endcase
				case ($urandom_range(4))
					0: anchor = 64'($urandom_range(0, 40));
					1: anchor = {1'b1, 31'($urandom), $urandom};
					2: anchor = total + 64'($urandom_range(0, 5));
					3: anchor = {$urandom, $urandom};
					default: anchor = {1'b0, total[63:1]};
				endcase
				send_word(mk_plan(anchor, total));
			end else if (k < 85) begin
				send_word(mk_write(12'($urandom_range(0, cap + 2 > 4095 ? 4095 : cap + 2)),
					3'($urandom_range(7)), rand_sample()));
			end else if (k < 90) begin
				// malformed publish: negative start, too many frames, or end past the top
				case ($urandom_range(2))
					0: send_word(mk_publish({1'b1, 31'($urandom), $urandom}, 13'($urandom_range(0, 8)),
						{$urandom, $urandom}, {$urandom, $urandom}));
					1: send_word(mk_publish(64'($urandom_range(0, 100)),
						13'(cap + $urandom_range(1, 8)), {$urandom, $urandom}, {$urandom, $urandom}));
					default: send_word(mk_publish(S64_MAX - 64'($urandom_range(0, 3)),
						13'($urandom_range(5, 12)), {$urandom, $urandom}, {$urandom, $urandom}));
				endcase
			end else begin
				send_word(rand_word());
			end
		end
	endtask

	initial begin
		int phase_end;
		mirror = new();
		arst_n <= 1'b0;
		start <= 1'b0;
		req <= '0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty window, plan clamps, write and publish limits, read edges
		send_word(mk_read(63'd0, 3'd0));
		send_word(mk_plan(64'd5, 64'd0));
		send_word(mk_plan(64'd5, S64_MIN));
		send_word(mk_plan(S64_MAX, S64_MAX));
		send_word(mk_plan(S64_MIN, 64'd10));
		send_word(mk_write(12'd0, 3'd7, 24'h123456));
		send_word(mk_write(12'd4095, 3'd0, 24'h7FFFFF));
		send_word(mk_write(12'd0, 3'd0, 24'h7FFFFF));
		send_word(mk_write(12'd1, 3'd0, 24'h800000));
		send_word(mk_publish(S64_MIN, 13'd1, 64'd1, 64'd1));
		send_word(mk_publish(64'd5, 13'd4097, 64'd2, 64'd2));
		send_word(mk_publish(64'd5, 13'h1FFF, 64'd3, 64'd3));
		send_word(mk_publish(S64_MAX, 13'd2, 64'd4, 64'd4));
		send_word(mk_publish(S64_MAX, 13'd1, '1, 64'd0));
		send_word(mk_publish(64'd5, 13'd0, {$urandom, $urandom}, 64'd7));
		send_word(mk_read({47'd5, 16'h0000}, 3'd0));
		send_word(mk_publish(64'd100, 13'd2, {$urandom, $urandom}, '1));
		send_word(mk_read({47'd100, 16'h0000}, 3'd0));
		send_word(mk_read({47'd100, 16'hFFFF}, 3'd0));
		send_word(mk_read({47'd100, 16'h0001}, 3'd0));
		send_word(mk_read({47'd99, 16'h0000}, 3'd0));
		send_word(mk_read({47'd101, 16'h0000}, 3'd0));
		send_word(mk_read({47'd101, 16'h0001}, 3'd0));
		send_word(mk_read({47'd102, 16'h0000}, 3'd0));
		send_word(mk_read({47'd100, 16'h0000}, 3'd1));
		send_word(mk_read('1, 3'd0));

		// random: sender idles 21 percent, then 74, then not at all
		for (int phase = 0; phase < 3; phase++) begin
			idle_pct = (phase == 0) ? 21 : (phase == 1) ? 74 : 0;
			drain();
			case (phase)
				0: set_regs(13'd8, 13'd1);
				1: set_regs(13'd1, 13'd4096);
				default: set_regs(13'd0, 13'd0);
			endcase
			phase_end = words_sent + PHASE_WORDS;
			while (words_sent < phase_end) begin
				if ($urandom_range(1) == 0) begin
					drain();
					set_regs(pick_channels(), pick_capacity());
				end
				run_scene();
			end
		end

		drain();
		repeat (10) @(posedge clk);
		$display("Run covered %0d request words under three sender idle rates and %0d register writes;",
			words_sent, cfg_writes);
		$display("%0d results were checked, %0d of them with a mismatch.", mirror.checked,
			mirror.mismatches);
		if (mirror.mismatches == 0)
			$display("tb_interpolating_pcm_window_store: PASS");
		else
			$display("tb_interpolating_pcm_window_store: FAIL");
		$finish;
	end

endmodule

/* interpolating_pcm_window_store.f */
+incdir+src
src/ipws_pkg.sv
src/ipws_store.sv
src/ipws_dp.sv
src/ipws_ctrl.sv
src/interpolating_pcm_window_store.sv
src/ipws_checker.sv
sim/tb_interpolating_pcm_window_store.sv
